// File: rtl/rar_pkg.sv
// ----------------------------------------------------------------------------
// rar_pkg
// Shared types and constants for the rational arithmetic reduction block:
// operation codes, output widths and the controller/datapath command and
// status groups.
// ----------------------------------------------------------------------------
package rar_pkg;

  // Default width of one input term
  localparam int TERM_WIDTH_DEF = 16;

  // Fixed output widths
  localparam int NUM_W = 33;
  localparam int DEN_W = 31;

  // Operation codes
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // capture a transaction, form magnitudes and signs
    logic mul_num;     // numerator product
    logic mul_cross;   // cross product for add and subtract
    logic mul_den;     // denominator product
    logic combine;     // combine numerator products, fix signs, seed the GCD
    logic gcd_step;    // one binary GCD step
    logic div_init;    // load dividends and divisor
    logic div_step;    // one restoring division step on both lanes
    logic finish;      // present the reduced fraction
    logic finish_err;  // present the error result
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic err;
    logic gcd_done;
    logic div_done;
  } dp_stat_t;

endpackage

// File: rtl/rar_datapath.sv
// ----------------------------------------------------------------------------
// rar_datapath
// Operand registers, one shared multiplier, numerator combine, an iterative
// binary GCD and a two-lane restoring divider that reduces both terms.
// ----------------------------------------------------------------------------
module rar_datapath #(
  parameter int TERM_WIDTH = rar_pkg::TERM_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  rar_pkg::dp_cmd_t          cmd,
  output rar_pkg::dp_stat_t         stat,
  input  logic [1:0]                op,
  input  logic [TERM_WIDTH-1:0]     a_num,
  input  logic [TERM_WIDTH-1:0]     a_den,
  input  logic [TERM_WIDTH-1:0]     b_num,
  input  logic [TERM_WIDTH-1:0]     b_den,
  output logic                      done,
  output logic [rar_pkg::NUM_W-1:0] res_num,
  output logic [rar_pkg::DEN_W-1:0] res_den,
  output logic                      bad
);
  import rar_pkg::*;

  localparam int W  = TERM_WIDTH;
  localparam int PW = 2 * TERM_WIDTH;
  localparam int KW = $clog2(PW + 1);
  localparam int XW = (PW > NUM_W) ? PW : NUM_W;

  // Captured operands
  op_t          op_r;
  logic [W-1:0] ma, mb, mc, md;
  logic         an, ad, bn, bd;
  logic         err;

  // Products and combined terms
  logic [PW-1:0] p1, p2, dp;
  logic [PW-1:0] nmag, dmag;
  logic          nneg;

  // GCD and divider state
  logic [PW-1:0] u, v;
  logic [KW-1:0] k;
  logic [PW-1:0] divisor;
  logic [PW-1:0] qn, qd, rn, rd;
  logic [KW-1:0] cnt;

  // Magnitudes of the incoming terms
  logic [W-1:0] ma_c, mb_c, mc_c, md_c;
  always_comb begin
    ma_c = a_num[W-1] ? W'(-a_num) : a_num;
    mb_c = a_den[W-1] ? W'(-a_den) : a_den;
    mc_c = b_num[W-1] ? W'(-b_num) : b_num;
    md_c = b_den[W-1] ? W'(-b_den) : b_den;
  end

  // Shared multiplier operand select
  logic [W-1:0]  mul_a, mul_b;
  logic [PW-1:0] mul_p;
  always_comb begin
    mul_a = mb;
    mul_b = mc;
    if (cmd.mul_num) begin
      mul_a = ma;
      mul_b = (op_r == OP_MUL) ? mc : md;
    end else if (cmd.mul_den) begin
      mul_a = mb;
      mul_b = (op_r == OP_DIV) ? mc : md;
    end
  end
  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // Combine numerator products and settle the sign
  logic          s1, s2, dneg_c, nneg_c;
  logic [PW-1:0] nmag_c;
  always_comb begin
    s1     = an ^ bd;
    s2     = ad ^ bn ^ (op_r == OP_SUB);
    nmag_c = p1;
    nneg_c = s1;
    dneg_c = ad ^ bd;
    case (op_r)
      OP_ADD, OP_SUB: begin
        if (s1 == s2) begin
          nmag_c = p1 + p2;
        end else if (p1 >= p2) begin
          nmag_c = p1 - p2;
        end else begin
          nmag_c = p2 - p1;
          nneg_c = s2;
        end
      end
      OP_MUL: begin
        nneg_c = an ^ bn;
      end
      OP_DIV: begin
        dneg_c = ad ^ bn;
      end
      default: begin
        nmag_c = p1;
      end
    endcase
  end

  // One binary GCD step
  logic          gcd_fin;
  logic [PW-1:0] u_next, v_next;
  logic [KW-1:0] k_next;
  always_comb begin
    gcd_fin = (u == '0) || (v == '0) || (u == v);
    u_next  = u;
    v_next  = v;
    k_next  = k;
    if (gcd_fin) begin
      u_next = u;
    end else if (!u[0] && !v[0]) begin
      u_next = u >> 1;
      v_next = v >> 1;
      k_next = k + 1'b1;
    end else if (!u[0]) begin
      u_next = u >> 1;
    end else if (!v[0]) begin
      v_next = v >> 1;
    end else if (u > v) begin
      u_next = (u - v) >> 1;
    end else begin
      v_next = (v - u) >> 1;
    end
  end

  // Restoring division step, both lanes share the divisor
  logic [PW:0]   tn, td;
  logic          gen, ged;
  always_comb begin
    tn  = {rn, qn[PW-1]};
    td  = {rd, qd[PW-1]};
    gen = tn >= {1'b0, divisor};
    ged = td >= {1'b0, divisor};
  end

  // Apply the sign and fit the output widths
  logic [XW-1:0] nx, nsig, dx;
  always_comb begin
    nx   = XW'(qn);
    nsig = nneg ? XW'(-nx) : nx;
    dx   = XW'(qd);
  end

  assign stat.err      = err;
  assign stat.gcd_done = gcd_fin;
  assign stat.div_done = (cnt == KW'(PW));

  // Operand and arithmetic registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= op_t'(op);
      ma   <= ma_c;
      mb   <= mb_c;
      mc   <= mc_c;
      md   <= md_c;
      an   <= a_num[W-1];
      ad   <= a_den[W-1];
      bn   <= b_num[W-1];
      bd   <= b_den[W-1];
      err  <= (mb_c == '0) || (md_c == '0) || ((op_t'(op) == OP_DIV) && (mc_c == '0));
    end
    if (cmd.mul_num) begin
      p1 <= mul_p;
    end
    if (cmd.mul_cross) begin
      p2 <= mul_p;
    end
    if (cmd.mul_den) begin
      dp <= mul_p;
    end
    if (cmd.combine) begin
      nmag <= nmag_c;
      dmag <= dp;
      nneg <= (nneg_c ^ dneg_c) && (nmag_c != '0);
      u    <= nmag_c;
      v    <= dp;
      k    <= '0;
    end
    if (cmd.gcd_step) begin
      u <= u_next;
      v <= v_next;
      k <= k_next;
    end
    if (cmd.div_init) begin
      divisor <= (u == '0) ? v : u;
      qn      <= nmag >> k;
      qd      <= dmag >> k;
      rn      <= '0;
      rd      <= '0;
      cnt     <= '0;
    end
    if (cmd.div_step) begin
      rn  <= gen ? PW'(tn - {1'b0, divisor}) : tn[PW-1:0];
      rd  <= ged ? PW'(td - {1'b0, divisor}) : td[PW-1:0];
      qn  <= {qn[PW-2:0], gen};
      qd  <= {qd[PW-2:0], ged};
      cnt <= cnt + 1'b1;
    end
  end

  // Result registers, the strobe lasts one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish || cmd.finish_err;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish_err) begin
      res_num <= '0;
      res_den <= '0;
      bad     <= 1'b1;
    end else if (cmd.finish) begin
      res_num <= nsig[NUM_W-1:0];
      res_den <= dx[DEN_W-1:0];
      bad     <= 1'b0;
    end
  end

endmodule

// File: rtl/rar_ctrl.sv
// ----------------------------------------------------------------------------
// rar_ctrl
// Sequencer for one transaction: three multiplies, combine, GCD iterations,
// division iterations, then the result strobe; an error skips the rest.
// ----------------------------------------------------------------------------
module rar_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output rar_pkg::dp_cmd_t  cmd,
  input  rar_pkg::dp_stat_t stat
);
  import rar_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MNUM = 7'b0000010,
    S_MCRS = 7'b0000100,
    S_MDEN = 7'b0001000,
    S_COMB = 7'b0010000,
    S_GCD  = 7'b0100000,
    S_DIV  = 7'b1000000
  } state_t;

  state_t state, state_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_MNUM;
        end
      end
      S_MNUM: begin
        if (stat.err) begin
          cmd.finish_err = 1'b1;
          state_next     = S_IDLE;
        end else begin
          cmd.mul_num = 1'b1;
          state_next  = S_MCRS;
        end
      end
      S_MCRS: begin
        cmd.mul_cross = 1'b1;
        state_next    = S_MDEN;
      end
      S_MDEN: begin
        cmd.mul_den = 1'b1;
        state_next  = S_COMB;
      end
      S_COMB: begin
        cmd.combine = 1'b1;
        state_next  = S_GCD;
      end
      S_GCD: begin
        if (stat.gcd_done) begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Advance the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

// File: rtl/rational_arith_reduce.sv
// The binary GCD advances one step a cycle. An error input finishes early:
// the controller presents the error result in place of the first multiply.
// A new transaction is taken only while idle; busy drops as done rises, so a
// new start may be taken in the done cycle. No result stall.
// Synchronous reset returns the controller to idle and clears done.
// ----------------------------------------------------------------------------
// rational_arith_reduce
// Adds, subtracts, multiplies or divides two signed fractions and reduces
// the result to lowest terms with the sign on the numerator.
// ----------------------------------------------------------------------------
module rational_arith_reduce #(
  parameter int TERM_WIDTH = rar_pkg::TERM_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                op,
  input  logic [TERM_WIDTH-1:0]     a_num,
  input  logic [TERM_WIDTH-1:0]     a_den,
  input  logic [TERM_WIDTH-1:0]     b_num,
  input  logic [TERM_WIDTH-1:0]     b_den,
  output logic                      done,
  output logic [rar_pkg::NUM_W-1:0] res_num,
  output logic [rar_pkg::DEN_W-1:0] res_den,
  output logic                      bad
);
  import rar_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer
  rar_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  // Arithmetic
  rar_datapath #(
    .TERM_WIDTH (TERM_WIDTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .op      (op),
    .a_num   (a_num),
    .a_den   (a_den),
    .b_num   (b_num),
    .b_den   (b_den),
    .done    (done),
    .res_num (res_num),
    .res_den (res_den),
    .bad     (bad)
  );

endmodule

// File: rtl/rar_check.sv
// ----------------------------------------------------------------------------
// rar_check
// Port-level checks on the transaction sequence and result encoding.
// ----------------------------------------------------------------------------
module rar_check (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic                      done,
  input logic [rar_pkg::NUM_W-1:0] res_num,
  input logic [rar_pkg::DEN_W-1:0] res_den,
  input logic                      bad
);
  import rar_pkg::*;

  // An accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted transaction");

  // No result follows an accept in the very next cycle
  a_accept_no_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("result strobe too early after accept");

  // The block is idle when it shows a result
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // Error results carry zero terms
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && bad) |-> (res_num == '0 && res_den == '0))
    else $error("error result with nonzero terms");

  // Good results have a nonzero denominator at the default width
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    (done && !bad) |-> (res_den != '0))
    else $error("good result with zero denominator");

endmodule

bind rational_arith_reduce rar_check u_rar_check (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .res_num (res_num),
  .res_den (res_den),
  .bad     (bad)
);
